FILE: rtl/core/mqtt_packet_deframer_defines.svh
// assertion macros for the packet deframer
`ifndef MQTT_PACKET_DEFRAMER_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked assertion with explicit clock and active-low reset
`define MPD_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the block clock and reset
`define MPD_ASSERT(label, prop, msg) `MPD_ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define MPD_ASSERT_AT(label, clk, rst_n, prop, msg)
`define MPD_ASSERT(label, prop, msg)
`endif

`endif

FILE: rtl/core/mpd_pkg.sv
// types, codes and constants shared by the packet deframer modules
`default_nettype none

package mpd_pkg;

  localparam int MaxLengthBytes = 4;
  localparam int LenW           = 28;
  localparam int TopicW         = 16;

  localparam logic [3:0] KindConnack  = 4'd2;
  localparam logic [3:0] KindPublish  = 4'd3;
  localparam logic [3:0] KindPuback   = 4'd4;
  localparam logic [3:0] KindPubrec   = 4'd5;
  localparam logic [3:0] KindPubrel   = 4'd6;
  localparam logic [3:0] KindPubcomp  = 4'd7;
  localparam logic [3:0] KindSuback   = 4'd9;
  localparam logic [3:0] KindUnsuback = 4'd11;
  localparam logic [3:0] KindPingresp = 4'd13;

  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhBody
  } phase_e;

  typedef enum logic [2:0] {
    ClsHeader,
    ClsLength,
    ClsTopicLen,
    ClsTopic,
    ClsPacketId,
    ClsPayload,
    ClsOther
  } class_e;

  typedef enum logic [2:0] {
    StMid,
    StOk,
    StConnackAcc,
    StConnackRej,
    StTooShort,
    StTopicOverrun,
    StMalformed,
    StUnknown
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [2:0]      byte_class;
    logic [3:0]      packet_kind;
    logic [3:0]      header_flags;
    logic [1:0]      qos_level;
    logic [LenW-1:0] body_length;
    logic            packet_end;
    logic [2:0]      packet_status;
    logic [7:0]      connack_code;
  } out_t;

  typedef struct packed {
    phase_e            phase;
    logic [3:0]        kind;
    logic [3:0]        flags;
    logic [LenW-1:0]   len_accum;
    logic [LenW-1:0]   body_cnt;
    logic [TopicW-1:0] topic_len;
    logic [7:0]        code;
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/mpd_judge.sv
// end-of-packet status from the packet kind, length, topic length and return code
`default_nettype none

module mpd_judge (
  input  mpd_pkg::state_t  st_i,
  output mpd_pkg::status_e status_o
);

  logic [mpd_pkg::LenW-1:0] topic_room;

  assign topic_room = st_i.len_accum - 28'd2;

  always_comb begin
    status_o = mpd_pkg::StUnknown;
    case (st_i.kind) inside
      mpd_pkg::KindConnack: begin
        if (st_i.len_accum < 28'd2) begin
          status_o = mpd_pkg::StTooShort;
        end else if (st_i.code == 8'd0) begin
          status_o = mpd_pkg::StConnackAcc;
        end else begin
          status_o = mpd_pkg::StConnackRej;
        end
      end
      mpd_pkg::KindPublish: begin
        if (st_i.len_accum < 28'd2) begin
          status_o = mpd_pkg::StTooShort;
        end else if (topic_room < {12'd0, st_i.topic_len}) begin
          status_o = mpd_pkg::StTopicOverrun;
        end else begin
          status_o = mpd_pkg::StOk;
        end
      end
      mpd_pkg::KindPuback, mpd_pkg::KindPubrec, mpd_pkg::KindPubrel,
      mpd_pkg::KindPubcomp, mpd_pkg::KindSuback, mpd_pkg::KindUnsuback,
      mpd_pkg::KindPingresp: begin
        status_o = mpd_pkg::StOk;
      end
      default: begin
        status_o = mpd_pkg::StUnknown;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpd_step.sv
// per-byte parse step: next parser state and the result item for one input byte
`default_nettype none

module mpd_step #(
  parameter  int MaxLengthBytes = mpd_pkg::MaxLengthBytes,
  localparam int CntW           = $clog2(MaxLengthBytes + 1)
) (
  input  mpd_pkg::state_t st_i,
  input  logic [CntW-1:0] cnt_i,
  input  mpd_pkg::in_t    item_i,
  output mpd_pkg::state_t st_o,
  output logic [CntW-1:0] cnt_o,
  output mpd_pkg::out_t   res_o
);

  mpd_pkg::state_t          st_d;
  logic [CntW-1:0]          cnt_d;
  mpd_pkg::phase_e          cur_phase;
  mpd_pkg::class_e          cls;
  mpd_pkg::status_e         judged;
  mpd_pkg::status_e         sts;
  logic                     end_judge;
  logic                     end_bad;
  logic [2:0]               cnt_w;
  logic [mpd_pkg::LenW-1:0] len_part;
  logic [mpd_pkg::LenW-1:0] body_inc;
  logic [mpd_pkg::LenW-1:0] topic_off;
  logic [mpd_pkg::LenW-1:0] id_off;
  logic [7:0]               b;

  assign b         = item_i.rx_byte;
  assign cnt_w     = 3'(cnt_i);
  assign body_inc  = st_i.body_cnt + 28'd1;
  assign topic_off = st_i.body_cnt - 28'd2;
  assign id_off    = topic_off - {12'd0, st_i.topic_len};

  // seven length bits placed by length byte position
  always_comb begin
    case (cnt_w[1:0])
      2'd0:    len_part = {21'd0, b[6:0]};
      2'd1:    len_part = {14'd0, b[6:0], 7'd0};
      2'd2:    len_part = {7'd0, b[6:0], 14'd0};
      default: len_part = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    st_d      = st_i;
    cnt_d     = cnt_i;
    cls       = mpd_pkg::ClsHeader;
    end_judge = 1'b0;
    end_bad   = 1'b0;
    cur_phase = item_i.restart ? mpd_pkg::PhHeader : st_i.phase;
    case (cur_phase)
      mpd_pkg::PhLength: begin
        cls            = mpd_pkg::ClsLength;
        st_d.len_accum = st_i.len_accum | len_part;
        cnt_d          = cnt_i + CntW'(1);
        if (b[7]) begin
          if (cnt_d >= CntW'(MaxLengthBytes)) begin
            end_bad    = 1'b1;
            st_d.phase = mpd_pkg::PhHeader;
          end
        end else if (st_d.len_accum == '0) begin
          end_judge  = 1'b1;
          st_d.phase = mpd_pkg::PhHeader;
        end else begin
          st_d.phase = mpd_pkg::PhBody;
        end
      end
      mpd_pkg::PhBody: begin
        if (st_i.kind == mpd_pkg::KindPublish) begin
          if (st_i.body_cnt < 28'd2) begin
            cls = mpd_pkg::ClsTopicLen;
          end else if (topic_off < {12'd0, st_i.topic_len}) begin
            cls = mpd_pkg::ClsTopic;
          end else if (st_i.flags[2:1] != 2'd0 && id_off < 28'd2) begin
            cls = mpd_pkg::ClsPacketId;
          end else begin
            cls = mpd_pkg::ClsPayload;
          end
          if (st_i.body_cnt == 28'd0) begin
            st_d.topic_len = {b, 8'd0};
          end else if (st_i.body_cnt == 28'd1) begin
            st_d.topic_len[7:0] = b;
          end
        end else begin
          cls = mpd_pkg::ClsOther;
          if (st_i.kind == mpd_pkg::KindConnack && st_i.body_cnt == 28'd1) begin
            st_d.code = b;
          end
        end
        st_d.body_cnt = body_inc;
        if (body_inc >= st_i.len_accum) begin
          end_judge  = 1'b1;
          st_d.phase = mpd_pkg::PhHeader;
        end
      end
      default: begin
        // fixed header byte opens a new packet
        st_d.kind      = b[7:4];
        st_d.flags     = b[3:0];
        st_d.len_accum = '0;
        st_d.body_cnt  = '0;
        st_d.topic_len = '0;
        st_d.code      = '0;
        cnt_d          = '0;
        st_d.phase     = mpd_pkg::PhLength;
      end
    endcase
  end

  mpd_judge u_judge (
    .st_i     (st_d),
    .status_o (judged)
  );

  always_comb begin
    if (end_bad) begin
      sts = mpd_pkg::StMalformed;
    end else if (end_judge) begin
      sts = judged;
    end else begin
      sts = mpd_pkg::StMid;
    end
  end

  always_comb begin
    res_o.data_byte     = b;
    res_o.byte_class    = cls;
    res_o.packet_kind   = st_d.kind;
    res_o.header_flags  = st_d.flags;
    res_o.qos_level     = (st_d.kind == mpd_pkg::KindPublish) ? st_d.flags[2:1] : 2'd0;
    res_o.body_length   = st_d.len_accum;
    res_o.packet_end    = end_bad | end_judge;
    res_o.packet_status = sts;
    res_o.connack_code  = (sts == mpd_pkg::StConnackAcc || sts == mpd_pkg::StConnackRej)
                          ? st_d.code : 8'd0;
  end

  assign st_o  = st_d;
  assign cnt_o = cnt_d;

endmodule

`default_nettype wire

FILE: rtl/core/mqtt_packet_deframer.sv
// top level of the byte-wise control packet deframer
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_t)
//
// one byte per cycle sustained while the output is not stalled; an item waits in the input register,
// then one pass of the parse step writes the result register and the parser state
// reset clears the parser state to waiting for a fixed header and empties both registers
// a stall on the output holds the result and the pending item, and input stalls only
// once both registers are full
`default_nettype none
`include "mqtt_packet_deframer_defines.svh"

module mqtt_packet_deframer #(
  parameter  int MaxLengthBytes = mpd_pkg::MaxLengthBytes,
  localparam int CntW           = $clog2(MaxLengthBytes + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpd_pkg::out_t out_data_o
);

  logic            in_vld_q;
  mpd_pkg::in_t    in_q;
  logic            out_vld_q;
  mpd_pkg::out_t   out_q;
  mpd_pkg::state_t st_q;
  mpd_pkg::state_t st_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  mpd_pkg::out_t   res;
  logic            adv;

  // the pending item moves on when the result register is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  mpd_step #(
    .MaxLengthBytes (MaxLengthBytes)
  ) u_step (
    .st_i   (st_q),
    .cnt_i  (cnt_q),
    .item_i (in_q),
    .st_o   (st_d),
    .cnt_o  (cnt_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: mpd_pkg::PhHeader, default: '0};
      cnt_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
        cnt_q     <= cnt_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `MPD_ASSERT(a_end_has_status,
    out_valid_o |-> (out_data_o.packet_end == (out_data_o.packet_status != mpd_pkg::StMid)),
    "packet end and status disagree")
  `MPD_ASSERT(a_header_not_end,
    out_valid_o && out_data_o.byte_class == mpd_pkg::ClsHeader |-> !out_data_o.packet_end,
    "header byte reported as packet end")
  `MPD_ASSERT(a_length_body_clear,
    st_q.phase == mpd_pkg::PhLength |-> st_q.body_cnt == '0,
    "body count not clear during length bytes")
  `MPD_ASSERT(a_pending_held,
    in_vld_q && !adv |=> in_vld_q && $stable(in_q),
    "pending item lost while output stalled")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the control packet deframer: directed rows, then random packets
`default_nettype none

module tb_top;
  import mpd_pkg::*;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  // parser state mirrored by the predictor
  phase_e      prs_phase;
  logic [3:0]  prs_kind;
  logic [3:0]  prs_flags;
  logic [27:0] prs_len;
  logic [2:0]  prs_lcnt;
  logic [27:0] prs_body;
  logic [15:0] prs_topic;
  logic [7:0]  prs_code;

  out_t parsed_q[$];
  row_t dir_rows[$];
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   errors      = 0;
  int   items_sent  = 0;
  int   results_cnt = 0;
  bit   cut_next    = 1'b0;

  mqtt_packet_deframer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [1:0] publish_qos();
    return (prs_kind == KindPublish) ? prs_flags[2:1] : 2'd0;
  endfunction

  function automatic status_e packet_verdict();
    case (prs_kind)
      KindConnack: begin
        if (prs_len < 2) return StTooShort;
        return (prs_code == 8'd0) ? StConnackAcc : StConnackRej;
      end
      KindPublish: begin
        if (prs_len < 2) return StTooShort;
        if (prs_len - 28'd2 < {12'd0, prs_topic}) return StTopicOverrun;
        return StOk;
      end
      KindPuback, KindPubrec, KindPubrel, KindPubcomp,
      KindSuback, KindUnsuback, KindPingresp: return StOk;
      default: return StUnknown;
    endcase
  endfunction

  // advances the mirrored parser by one byte and returns the classified byte
  function automatic out_t parse_byte(in_t d);
    out_t        r;
    logic [7:0]  b;
    logic [27:0] idx;
    class_e      cls;
    status_e     st;
    logic        fin;
    b   = d.rx_byte;
    cls = ClsHeader;
    st  = StMid;
    fin = 1'b0;
    if (d.restart) prs_phase = PhHeader;
    case (prs_phase)
      PhLength: begin
        cls = ClsLength;
        if (prs_lcnt < 4) prs_len = prs_len | (28'(b[6:0]) << (7 * prs_lcnt[1:0]));
        prs_lcnt = prs_lcnt + 3'd1;
        if (b[7]) begin
          if (prs_lcnt >= MaxLengthBytes) begin
            fin       = 1'b1;
            st        = StMalformed;
            prs_phase = PhHeader;
          end
        end else if (prs_len == 28'd0) begin
          fin       = 1'b1;
          st        = packet_verdict();
          prs_phase = PhHeader;
        end else begin
          prs_phase = PhBody;
        end
      end
      PhBody: begin
        idx = prs_body;
        if (prs_kind == KindPublish) begin
          if (idx < 2) cls = ClsTopicLen;
          else if (idx - 28'd2 < {12'd0, prs_topic}) cls = ClsTopic;
          else if (publish_qos() != 2'd0 && idx - 28'd2 - {12'd0, prs_topic} < 2)
            cls = ClsPacketId;
          else cls = ClsPayload;
          if (idx == 0) prs_topic = {b, 8'h00};
          else if (idx == 1) prs_topic[7:0] = b;
        end else begin
          cls = ClsOther;
          if (prs_kind == KindConnack && idx == 1) prs_code = b;
        end
        prs_body = prs_body + 28'd1;
        if (prs_body >= prs_len) begin
          fin       = 1'b1;
          st        = packet_verdict();
          prs_phase = PhHeader;
        end
      end
      default: begin
        prs_kind  = b[7:4];
        prs_flags = b[3:0];
        prs_len   = '0;
        prs_lcnt  = '0;
        prs_body  = '0;
        prs_topic = '0;
        prs_code  = '0;
        prs_phase = PhLength;
      end
    endcase
    r.data_byte     = b;
    r.byte_class    = cls;
    r.packet_kind   = prs_kind;
    r.header_flags  = prs_flags;
    r.qos_level     = publish_qos();
    r.body_length   = prs_len;
    r.packet_end    = fin;
    r.packet_status = st;
    r.connack_code  = (st == StConnackAcc || st == StConnackRej) ? prs_code : 8'd0;
    return r;
  endfunction

  function automatic row_t stim(logic [7:0] b, logic rs);
    row_t r;
    r.stim  = '{rx_byte: b, restart: rs};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t stim_exp(logic [7:0] b, logic rs, class_e c, logic [3:0] k,
                                    logic [3:0] f, logic [1:0] q, logic [27:0] len,
                                    logic fin, status_e st, logic [7:0] code);
    row_t r;
    r       = stim(b, rs);
    r.typed = 1'b1;
    r.want  = '{data_byte: b, byte_class: c, packet_kind: k, header_flags: f,
                qos_level: q, body_length: len, packet_end: fin, packet_status: st,
                connack_code: code};
    return r;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch at result %0d: %s got %0h want %0h", results_cnt, what, got, want);
  endtask

  task automatic send_byte(input in_t d, input bit typed, input out_t want);
    out_t pred;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pred = parse_byte(d);
    parsed_q.insert(parsed_q.size(), typed ? want : pred);
    items_sent++;
  endtask

  // builds one random packet (mostly well formed) and sends it byte by byte
  task automatic send_random_packet();
    logic [7:0]  bytes[$];
    logic [7:0]  g;
    logic [3:0]  k;
    logic [3:0]  f;
    logic [15:0] tl_decl;
    int          pick;
    int          blen;
    int          tl;
    int          nlen;
    bit          long_len;
    bit          noise;
    bit          malformed;
    bit          rs;
    pick      = $urandom_range(99);
    k         = 4'($urandom_range(15));
    f         = 4'($urandom_range(15));
    long_len  = 1'b0;
    noise     = 1'b0;
    malformed = 1'b0;
    if (pick < 40) begin
      k  = KindPublish;
      tl = $urandom_range(6);
      tl_decl = 16'(tl);
      if ($urandom_range(99) < 10) tl_decl = 16'($urandom);
      else if ($urandom_range(99) < 15) tl_decl = 16'(tl + $urandom_range(1, 5));
      bytes.insert(bytes.size(), tl_decl[15:8]);
      bytes.insert(bytes.size(), tl_decl[7:0]);
      repeat (tl) bytes.insert(bytes.size(), 8'($urandom));
      if (f[2:1] != 2'd0) repeat (2) bytes.insert(bytes.size(), 8'($urandom));
      repeat ($urandom_range(8)) bytes.insert(bytes.size(), 8'($urandom));
      blen = bytes.size();
      if ($urandom_range(99) < 5) blen = $urandom_range(1);
    end else if (pick < 55) begin
      k    = KindConnack;
      blen = ($urandom_range(99) < 80) ? 2 : $urandom_range(4);
      bytes.insert(bytes.size(), 8'($urandom));
      bytes.insert(bytes.size(), $urandom_range(1) ? 8'd0 : 8'($urandom));
      repeat (2) bytes.insert(bytes.size(), 8'($urandom));
    end else if (pick < 88) begin
      if (k == KindConnack || k == KindPublish) k = KindPuback;
      blen = ($urandom_range(1)) ? 2 : $urandom_range(5);
      repeat (5) bytes.insert(bytes.size(), 8'($urandom));
    end else if (pick < 94) begin
      long_len = 1'b1;
      blen     = int'($urandom & 32'h0FFF_FFFF);
      repeat ($urandom_range(5)) bytes.insert(bytes.size(), 8'($urandom));
    end else if (pick < 97) begin
      malformed = 1'b1;
    end else begin
      noise = 1'b1;
    end

    rs = cut_next ? 1'b1 : ($urandom_range(3) == 0);
    cut_next = 1'b0;
    if (noise) begin
      repeat ($urandom_range(1, 6))
        send_byte('{rx_byte: 8'($urandom), restart: ($urandom_range(3) == 0)}, 1'b0, '0);
      cut_next = 1'b1;
      return;
    end
    send_byte('{rx_byte: {k, f}, restart: rs}, 1'b0, '0);
    if (malformed) begin
      repeat (4) send_byte('{rx_byte: 8'($urandom) | 8'h80, restart: 1'b0}, 1'b0, '0);
      return;
    end

    // remaining length, sometimes padded with redundant continuation bytes
    nlen = 1;
    while (nlen < 4 && (blen >> (7 * nlen)) != 0) nlen++;
    if ($urandom_range(9) == 0) nlen = $urandom_range(nlen, 4);
    for (int i = 0; i < nlen; i++) begin
      g = 8'((blen >> (7 * i)) & 'h7F);
      if (i < nlen - 1) g[7] = 1'b1;
      send_byte('{rx_byte: g, restart: 1'b0}, 1'b0, '0);
    end
    if (long_len) begin
      foreach (bytes[i]) send_byte('{rx_byte: bytes[i], restart: 1'b0}, 1'b0, '0);
      cut_next = 1'b1;
    end else begin
      for (int i = 0; i < blen; i++)
        send_byte('{rx_byte: bytes[i], restart: 1'b0}, 1'b0, '0);
    end
  endtask

  // result side: random stalls and in-order checking
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_cnt++;
      if (parsed_q.size() == 0) begin
        report_mismatch("item with nothing expected", 32'(out_data_o.data_byte), 32'd0);
      end else begin
        want = parsed_q.pop_front();
        if (out_data_o.data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(out_data_o.data_byte), 32'(want.data_byte));
        if (out_data_o.byte_class !== want.byte_class)
          report_mismatch("byte_class", 32'(out_data_o.byte_class), 32'(want.byte_class));
        if (out_data_o.packet_kind !== want.packet_kind)
          report_mismatch("packet_kind", 32'(out_data_o.packet_kind),
                          32'(want.packet_kind));
        if (out_data_o.header_flags !== want.header_flags)
          report_mismatch("header_flags", 32'(out_data_o.header_flags),
                          32'(want.header_flags));
        if (out_data_o.qos_level !== want.qos_level)
          report_mismatch("qos_level", 32'(out_data_o.qos_level), 32'(want.qos_level));
        if (out_data_o.body_length !== want.body_length)
          report_mismatch("body_length", 32'(out_data_o.body_length),
                          32'(want.body_length));
        if (out_data_o.packet_end !== want.packet_end)
          report_mismatch("packet_end", 32'(out_data_o.packet_end), 32'(want.packet_end));
        if (out_data_o.packet_status !== want.packet_status)
          report_mismatch("packet_status", 32'(out_data_o.packet_status),
                          32'(want.packet_status));
        if (out_data_o.connack_code !== want.connack_code)
          report_mismatch("connack_code", 32'(out_data_o.connack_code),
                          32'(want.connack_code));
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 64, 0, 7};
    stall_set = '{0, 0, 64, 7};
    prs_phase = PhHeader;
    prs_kind  = '0;
    prs_flags = '0;
    prs_len   = '0;
    prs_lcnt  = '0;
    prs_body  = '0;
    prs_topic = '0;
    prs_code  = '0;

    // connack rejected with its return code
    add_row(stim_exp(8'h20, 1'b1, ClsHeader, 4'd2, 4'd0, 2'd0, 28'd0, 1'b0,
                     StMid, 8'h00));
    add_row(stim_exp(8'h02, 1'b0, ClsLength, 4'd2, 4'd0, 2'd0, 28'd2, 1'b0,
                     StMid, 8'h00));
    add_row(stim(8'h00, 1'b0));
    add_row(stim_exp(8'h05, 1'b0, ClsOther, 4'd2, 4'd0, 2'd0, 28'd2, 1'b1,
                     StConnackRej, 8'h05));
    // unknown kind, continuation bit on every length byte
    add_row(stim(8'hFF, 1'b0));
    repeat (3) add_row(stim(8'hFF, 1'b0));
    add_row(stim_exp(8'hFF, 1'b0, ClsLength, 4'd15, 4'd15, 2'd0, 28'hFFF_FFFF,
                     1'b1, StMalformed, 8'h00));
    // publish with zero remaining length is too short
    add_row(stim(8'h30, 1'b0));
    add_row(stim_exp(8'h00, 1'b0, ClsLength, 4'd3, 4'd0, 2'd0, 28'd0, 1'b1,
                     StTooShort, 8'h00));
    // topic length beyond the body
    add_row(stim(8'h30, 1'b0));
    add_row(stim(8'h02, 1'b0));
    add_row(stim(8'h00, 1'b0));
    add_row(stim_exp(8'h01, 1'b0, ClsTopicLen, 4'd3, 4'd0, 2'd0, 28'd2, 1'b1,
                     StTopicOverrun, 8'h00));
    // partial packet dropped by a restart
    add_row(stim(8'h3B, 1'b0));
    add_row(stim(8'h0A, 1'b0));
    // qos 1 publish: topic length, topic, packet id, payload
    add_row(stim(8'h32, 1'b1));
    add_row(stim(8'h06, 1'b0));
    add_row(stim(8'h00, 1'b0));
    add_row(stim(8'h01, 1'b0));
    add_row(stim(8'h61, 1'b0));
    add_row(stim(8'h00, 1'b0));
    add_row(stim(8'h01, 1'b0));
    add_row(stim(8'h58, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    items_sent = 0;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      while (items_sent < 375 * (p + 1)) send_random_packet();
    end
    in_valid_i <= 1'b0;

    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/mpd_pkg.sv
rtl/core/mpd_judge.sv
rtl/core/mpd_step.sv
rtl/core/mqtt_packet_deframer.sv
tb/tb_top.sv
